@@ rtl/core/uvps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// uvps_pkg
// Shared types and constants of the UV peak sweep locator: item layouts,
// register map, drive and outcome codes, sequencer states.
// ----------------------------------------------------------------------------
package uvps_pkg;

   // Field widths fixed by the item and register layouts
   localparam int SWEEP_TICKS_W  = 12;
   localparam int UV_THRESHOLD_W = 10;
   localparam int MOTOR_SPEED_W  = 8;
   localparam int UV_W           = 10;
   localparam int DRIVE_W        = 2;
   localparam int OUTCOME_W      = 2;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 12;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   // Register map
   localparam logic [CSR_ADDR_W-1:0] REG_SWEEP_TICKS  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_UV_THRESHOLD = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MOTOR_SPEED  = 2'd2;

   // Register reset values
   localparam logic [SWEEP_TICKS_W-1:0]  SWEEP_TICKS_RST  = 12'd64;
   localparam logic [UV_THRESHOLD_W-1:0] UV_THRESHOLD_RST = 10'd512;
   localparam logic [MOTOR_SPEED_W-1:0]  MOTOR_SPEED_RST  = 8'd0;

   // Position classification: side at a tenth of a sweep, corner at eight tenths
   localparam int CLASS_SCALE  = 10;
   localparam int CORNER_SCALE = 8;

   typedef enum logic [DRIVE_W-1:0] {
      DRV_BRAKE = 2'd0,
      DRV_FWD   = 2'd1,
      DRV_BACK  = 2'd2
   } drive_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_NONE   = 2'd0,
      OUT_SIDE   = 2'd1,
      OUT_CORNER = 2'd2,
      OUT_AHEAD  = 2'd3
   } outcome_type;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_SWEEP   = 5'b00010,
      PH_EXTRA   = 5'b00100,
      PH_REVERSE = 5'b01000,
      PH_CENTER  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [SWEEP_TICKS_W-1:0]  sweep_ticks;
      logic [UV_THRESHOLD_W-1:0] uv_threshold;
      logic [MOTOR_SPEED_W-1:0]  motor_speed;
   } cfg_type;

   typedef struct packed {
      logic            start_req;
      logic            turn_right;
      logic            odometry_level;
      logic [UV_W-1:0] uv_left;
      logic [UV_W-1:0] uv_right;
   } req_type;

   typedef struct packed {
      drive_type                left_drive;
      drive_type                right_drive;
      logic [MOTOR_SPEED_W-1:0] drive_speed;
      logic                     busy_res;
      logic                     done_res;
      outcome_type              outcome;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/uvps_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// uvps_engine
// Sweep sequencer: holds the sequence state and turns one sample into one
// motor command per advance.
// ----------------------------------------------------------------------------
module uvps_engine #(
   parameter int COUNT_WIDTH  = 12,
   parameter int SAMPLE_WIDTH = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire uvps_pkg::req_type item,
   input  wire uvps_pkg::cfg_type cfg,
   output uvps_pkg::rsp_type      result
);

   localparam int POS_W = COUNT_WIDTH + 4;
   localparam int CMP_W = (SAMPLE_WIDTH > uvps_pkg::UV_THRESHOLD_W) ?
                          SAMPLE_WIDTH : uvps_pkg::UV_THRESHOLD_W;

   uvps_pkg::phase_type     phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]  ticks_ff, ticks_in;
   logic [SAMPLE_WIDTH-1:0] peak_ff, peak_in;
   logic [COUNT_WIDTH-1:0]  pos_ff, pos_in;
   logic                    level_ff, level_in;
   logic                    right_ff, right_in;
   uvps_pkg::outcome_type   outcome_ff, outcome_in;

   logic [SAMPLE_WIDTH-1:0] uvl, uvr, uv_max;
   logic [COUNT_WIDTH-1:0]  full;
   logic [POS_W-1:0]        pos10, full8;
   uvps_pkg::outcome_type   cls;
   logic                    turning, turn_r, done, met;

   assign uvl    = SAMPLE_WIDTH'(item.uv_left);
   assign uvr    = SAMPLE_WIDTH'(item.uv_right);
   assign uv_max = (uvl > uvr) ? uvl : uvr;
   assign full   = COUNT_WIDTH'(cfg.sweep_ticks);

   // Classify the stored position against fractions of the sweep
   assign pos10 = POS_W'(pos_ff) * POS_W'(uvps_pkg::CLASS_SCALE);
   assign full8 = POS_W'(full) * POS_W'(uvps_pkg::CORNER_SCALE);
   always_comb begin
      priority if (pos10 <= POS_W'(full)) begin
         cls = uvps_pkg::OUT_SIDE;
      end else if (pos10 <= full8) begin
         cls = uvps_pkg::OUT_CORNER;
      end else begin
         cls = uvps_pkg::OUT_AHEAD;
      end
   end

   assign met = right_ff ? (uvr >= uvl) : (uvl >= uvr);

   always_comb begin
      phase_in   = phase_ff;
      ticks_in   = ticks_ff;
      peak_in    = peak_ff;
      pos_in     = pos_ff;
      level_in   = level_ff;
      right_in   = right_ff;
      outcome_in = outcome_ff;
      turning    = 1'b0;
      turn_r     = 1'b0;
      done       = 1'b0;
      unique case (phase_ff)
         uvps_pkg::PH_SWEEP: begin
            if (ticks_ff != '0) begin
               if (uv_max > peak_ff) begin
                  peak_in = uv_max;
                  pos_in  = ticks_ff;
               end
               if (item.odometry_level != level_ff) begin
                  ticks_in = ticks_ff - COUNT_WIDTH'(1);
                  level_in = item.odometry_level;
               end
            end
            turning = 1'b1;
            turn_r  = right_ff;
            if (ticks_in == '0) begin
               level_in = item.odometry_level;
               if (CMP_W'(peak_in) < CMP_W'(cfg.uv_threshold)) begin
                  phase_in = uvps_pkg::PH_EXTRA;
                  ticks_in = full;
               end else begin
                  phase_in = uvps_pkg::PH_REVERSE;
                  ticks_in = pos_in;
                  turn_r   = !right_ff;
               end
            end
         end
         uvps_pkg::PH_EXTRA: begin
            if (ticks_ff != '0 && item.odometry_level != level_ff) begin
               ticks_in = ticks_ff - COUNT_WIDTH'(1);
               level_in = item.odometry_level;
            end
            turning = 1'b1;
            turn_r  = right_ff;
            if (ticks_in == '0) begin
               turning    = 1'b0;
               done       = 1'b1;
               outcome_in = uvps_pkg::OUT_NONE;
               phase_in   = uvps_pkg::PH_IDLE;
            end
         end
         uvps_pkg::PH_REVERSE, uvps_pkg::PH_CENTER: begin
            if (phase_ff == uvps_pkg::PH_REVERSE) begin
               if (ticks_ff != '0 && item.odometry_level != level_ff) begin
                  ticks_in = ticks_ff - COUNT_WIDTH'(1);
                  level_in = item.odometry_level;
               end
               if (ticks_in == '0) begin
                  phase_in = uvps_pkg::PH_CENTER;
               end
            end
            turning = 1'b1;
            turn_r  = !right_ff;
            if (phase_in == uvps_pkg::PH_CENTER && met) begin
               turning    = 1'b0;
               done       = 1'b1;
               outcome_in = cls;
               phase_in   = uvps_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = uvps_pkg::PH_IDLE;
            if (item.start_req) begin
               right_in = item.turn_right;
               ticks_in = full;
               peak_in  = '0;
               pos_in   = '0;
               level_in = item.odometry_level;
               phase_in = uvps_pkg::PH_SWEEP;
               turning  = 1'b1;
               turn_r   = item.turn_right;
            end
         end
      endcase
   end

   always_comb begin
      if (turning) begin
         result.left_drive  = turn_r ? uvps_pkg::DRV_FWD : uvps_pkg::DRV_BACK;
         result.right_drive = turn_r ? uvps_pkg::DRV_BACK : uvps_pkg::DRV_FWD;
         result.drive_speed = cfg.motor_speed;
      end else begin
         result.left_drive  = uvps_pkg::DRV_BRAKE;
         result.right_drive = uvps_pkg::DRV_BRAKE;
         result.drive_speed = '0;
      end
      result.busy_res = (phase_in != uvps_pkg::PH_IDLE);
      result.done_res = done;
      result.outcome  = outcome_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= uvps_pkg::PH_IDLE;
         ticks_ff   <= '0;
         peak_ff    <= '0;
         pos_ff     <= '0;
         level_ff   <= 1'b0;
         right_ff   <= 1'b0;
         outcome_ff <= uvps_pkg::OUT_NONE;
      end else if (advance) begin
         phase_ff   <= phase_in;
         ticks_ff   <= ticks_in;
         peak_ff    <= peak_in;
         pos_ff     <= pos_in;
         level_ff   <= level_in;
         right_ff   <= right_in;
         outcome_ff <= outcome_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/uv_peak_sweep_locator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// uv_peak_sweep_locator_top
// UV peak sweep locator with sample stream in, motor command stream out and
// a register write port.
// ----------------------------------------------------------------------------
// One sample item in gives one command item out. The block takes an item on
// every clock when the result side keeps up: a sample is held in the input
// register, the sequencer next-state logic works it against the held sweep
// state, and the command lands in the output register. Each advance updates
// the whole sequencer state, which sets the rate of one item per clock. A
// start sample begins a sweep of sweep_ticks encoder edges; the commands
// then drive the turn, the turn back toward the peak or, when the peak stays
// under uv_threshold, an extra sweep, and the final brake, with done on
// rsp_tlast and the outcome in rsp_tdata. Registers are to be written through
// csr_ only while no sequence is running; the block does not enforce it.
module uv_peak_sweep_locator_top #(
   parameter int COUNT_WIDTH  = 12,
   parameter int SAMPLE_WIDTH = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Sample items
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [0] start_req, [1] turn_right, [2] odometry_level,
   // [12:3] uv_left, [22:13] uv_right, [23] zero
   input  wire logic [uvps_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Command items
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [1:0] left_drive, [3:2] right_drive, [11:4] drive_speed,
   // [12] busy_res, [14:13] outcome, [15] zero
   output logic [uvps_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // done_res
   output logic                                   rsp_tlast,
   // Register writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [uvps_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [uvps_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   uvps_pkg::cfg_type cfg_ff;
   uvps_pkg::req_type req_ff;
   logic              req_valid_ff;
   uvps_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;
   uvps_pkg::rsp_type step_rsp;
   uvps_pkg::req_type req_item;
   logic              advance;

   // Unpack the sample item
   assign req_item.start_req      = req_tdata[0];
   assign req_item.turn_right     = req_tdata[1];
   assign req_item.odometry_level = req_tdata[2];
   assign req_item.uv_left        = req_tdata[12:3];
   assign req_item.uv_right       = req_tdata[22:13];

   // Move the held sample into the sequencer when the output slot frees up
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign csr_ready  = 1'b1;

   uvps_engine #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_ff),
      .cfg     (cfg_ff),
      .result  (step_rsp)
   );

   // Register file: drop writes to unmapped indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sweep_ticks  <= uvps_pkg::SWEEP_TICKS_RST;
         cfg_ff.uv_threshold <= uvps_pkg::UV_THRESHOLD_RST;
         cfg_ff.motor_speed  <= uvps_pkg::MOTOR_SPEED_RST;
      end else if (csr_valid) begin
         unique case (csr_addr)
            uvps_pkg::REG_SWEEP_TICKS: begin
               cfg_ff.sweep_ticks <= csr_wdata;
            end
            uvps_pkg::REG_UV_THRESHOLD: begin
               cfg_ff.uv_threshold <= csr_wdata[uvps_pkg::UV_THRESHOLD_W-1:0];
            end
            uvps_pkg::REG_MOTOR_SPEED: begin
               cfg_ff.motor_speed <= csr_wdata[uvps_pkg::MOTOR_SPEED_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input register: hold the sample until the sequencer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_item;
      end
   end

   // Output register: hold the command until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.done_res;
   assign rsp_tdata  = {1'b0, rsp_ff.outcome, rsp_ff.busy_res, rsp_ff.drive_speed,
                        rsp_ff.right_drive, rsp_ff.left_drive};

`ifndef SYNTHESIS
   // A finishing command always brakes and leaves the block idle
   a_done_brakes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |->
         !rsp_ff.busy_res && rsp_ff.left_drive == uvps_pkg::DRV_BRAKE &&
         rsp_ff.right_drive == uvps_pkg::DRV_BRAKE)
      else $error("done command without brake or with busy set");

   // A held sample is never lost while the output side stalls
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_ff))
      else $error("held sample lost or changed");

   // A stalled command keeps its slot and its contents
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled command lost or changed");
`endif

endmodule
`default_nettype wire

@@ test/uv_peak_sweep_locator_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_peak_sweep_locator_top_test
// Self-checking bench for the UV peak sweep locator. A driver feeds sensor
// items from a queue and a monitor compares every command item with the
// command that a local copy of the sweep sequencer predicts. A short directed
// part covers every outcome, a zero-length sweep and a long sweep. After
// that come random phases of well-formed sweep sequences mixed with noise,
// each phase under its own register settings, with random gaps on both
// sides after the first phase and long receiver holds.
// ----------------------------------------------------------------------------
module uv_peak_sweep_locator_top_test;

   localparam int STALL_LIMIT = 2000;   // cycles with no handshake at all
   localparam int HOLD_CYCLES = 300;    // long receiver hold
   localparam int RAND_PHASES = 8;
   localparam int PHASE_ITEMS = 140;

   // Sequencer state as the predictor keeps it
   typedef struct packed {
      uvps_pkg::phase_type                ph;
      logic [uvps_pkg::SWEEP_TICKS_W-1:0] ticks_left;
      logic [uvps_pkg::UV_W-1:0]          peak;
      logic [uvps_pkg::SWEEP_TICKS_W-1:0] peak_pos;
      logic                               last_lvl;
      logic                               sweep_r;
      uvps_pkg::outcome_type              last_out;
   } locator_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [uvps_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [uvps_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              rsp_tlast;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [uvps_pkg::CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [uvps_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   // Stimulus and expectations
   uvps_pkg::req_type sensor_q[$];
   uvps_pkg::rsp_type command_q[$];
   locator_state_type model_st;   // advanced on each accepted item
   locator_state_type plan_st;    // advanced as items are queued, shapes stimulus
   uvps_pkg::cfg_type model_cfg = '{sweep_ticks: uvps_pkg::SWEEP_TICKS_RST,
                                    uv_threshold: uvps_pkg::UV_THRESHOLD_RST,
                                    motor_speed: uvps_pkg::MOTOR_SPEED_RST};

   int mismatches    = 0;
   int planned       = 0;
   int rsp_count     = 0;
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int toggle_pct    = 100;
   int uv_cap        = 1023;
   int send_gap      = 0;
   int stall_left    = 0;
   int hold_left     = 0;
   int next_hold_at  = 300;
   int quiet_cycles  = 0;
   logic req_fired   = 1'b0;

   uv_peak_sweep_locator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Take one encoder edge off the remaining count when the level moved.
   function automatic void count_edge(inout locator_state_type st, input logic lvl);
      if (st.ticks_left != 0 && lvl != st.last_lvl) begin
         st.ticks_left = st.ticks_left - 1'b1;
         st.last_lvl   = lvl;
      end
   endfunction

   // Advance the sweep sequencer by one sensor item and return its command.
   function automatic uvps_pkg::rsp_type step_locator(inout locator_state_type st,
                                                      input uvps_pkg::cfg_type cfg,
                                                      input uvps_pkg::req_type s);
      uvps_pkg::rsp_type         r;
      logic                      turning;
      logic                      turn_r;
      logic                      done;
      logic                      met;
      logic [uvps_pkg::UV_W-1:0] hi;
      int unsigned               pos10;
      int unsigned               full;
      turning = 1'b0;
      turn_r  = 1'b0;
      done    = 1'b0;
      case (st.ph)
         uvps_pkg::PH_SWEEP: begin
            if (st.ticks_left != 0) begin
               hi = (s.uv_left > s.uv_right) ? s.uv_left : s.uv_right;
               if (hi > st.peak) begin
                  st.peak     = hi;
                  st.peak_pos = st.ticks_left;
               end
               count_edge(st, s.odometry_level);
            end
            turning = 1'b1;
            turn_r  = st.sweep_r;
            // The sweep ends on the tick that the count runs out
            if (st.ticks_left == 0) begin
               st.last_lvl = s.odometry_level;
               if (st.peak < cfg.uv_threshold) begin
                  st.ph         = uvps_pkg::PH_EXTRA;
                  st.ticks_left = cfg.sweep_ticks;
               end else begin
                  st.ph         = uvps_pkg::PH_REVERSE;
                  st.ticks_left = st.peak_pos;
                  turn_r        = ~st.sweep_r;
               end
            end
         end
         uvps_pkg::PH_EXTRA: begin
            count_edge(st, s.odometry_level);
            turning = 1'b1;
            turn_r  = st.sweep_r;
            if (st.ticks_left == 0) begin
               turning     = 1'b0;
               done        = 1'b1;
               st.last_out = uvps_pkg::OUT_NONE;
               st.ph       = uvps_pkg::PH_IDLE;
            end
         end
         uvps_pkg::PH_REVERSE, uvps_pkg::PH_CENTER: begin
            if (st.ph == uvps_pkg::PH_REVERSE) begin
               count_edge(st, s.odometry_level);
               if (st.ticks_left == 0) st.ph = uvps_pkg::PH_CENTER;
            end
            turning = 1'b1;
            turn_r  = ~st.sweep_r;
            // Centering is checked on the same tick the turn back runs out
            if (st.ph == uvps_pkg::PH_CENTER) begin
               met = st.sweep_r ? (s.uv_right >= s.uv_left) : (s.uv_left >= s.uv_right);
               if (met) begin
                  turning = 1'b0;
                  done    = 1'b1;
                  pos10   = int'(st.peak_pos) * uvps_pkg::CLASS_SCALE;
                  full    = int'(cfg.sweep_ticks);
                  if (pos10 <= full) begin
                     st.last_out = uvps_pkg::OUT_SIDE;
                  end else if (pos10 <= full * uvps_pkg::CORNER_SCALE) begin
                     st.last_out = uvps_pkg::OUT_CORNER;
                  end else begin
                     st.last_out = uvps_pkg::OUT_AHEAD;
                  end
                  st.ph = uvps_pkg::PH_IDLE;
               end
            end
         end
         default: begin
            st.ph = uvps_pkg::PH_IDLE;
            if (s.start_req) begin
               st.sweep_r    = s.turn_right;
               st.ticks_left = cfg.sweep_ticks;
               st.peak       = '0;
               st.peak_pos   = '0;
               st.last_lvl   = s.odometry_level;
               st.ph         = uvps_pkg::PH_SWEEP;
               turning       = 1'b1;
               turn_r        = s.turn_right;
            end
         end
      endcase

      if (turning) begin
         r.left_drive  = turn_r ? uvps_pkg::DRV_FWD : uvps_pkg::DRV_BACK;
         r.right_drive = turn_r ? uvps_pkg::DRV_BACK : uvps_pkg::DRV_FWD;
         r.drive_speed = cfg.motor_speed;
      end else begin
         r.left_drive  = uvps_pkg::DRV_BRAKE;
         r.right_drive = uvps_pkg::DRV_BRAKE;
         r.drive_speed = '0;
      end
      r.busy_res = (st.ph != uvps_pkg::PH_IDLE);
      r.done_res = done;
      r.outcome  = st.last_out;
      return r;
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endfunction

   // Mostly no gap, some short ones, a few long ones.
   function automatic int pick_gap(int idle_pct);
      if ($urandom_range(0, 99) >= idle_pct) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: present queued sensor items, one per handshake
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (sensor_q.size() != 0) begin
            req_tdata  <= {1'b0, sensor_q[0].uv_right, sensor_q[0].uv_left,
                           sensor_q[0].odometry_level, sensor_q[0].turn_right,
                           sensor_q[0].start_req};
            void'(sensor_q.pop_front());
            req_tvalid <= 1'b1;
            send_gap = pick_gap(req_idle_pct);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls plus a long hold every few hundred commands, so
   // the block backs up and has to stall its input side
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_count >= next_hold_at) begin
         hold_left = HOLD_CYCLES;
         next_hold_at += 700;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap(rsp_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check accepted commands first, then predict from the accepted
   // sensor item, then run the watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      uvps_pkg::req_type s;
      uvps_pkg::rsp_type want;
      req_fired <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (command_q.size() == 0) begin
            mismatches++;
            $display("%0t: command item with nothing expected, got data %h last %b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            want = command_q.pop_front();
            check_field("left_drive",  want.left_drive,  rsp_tdata[1:0]);
            check_field("right_drive", want.right_drive, rsp_tdata[3:2]);
            check_field("drive_speed", want.drive_speed, rsp_tdata[11:4]);
            check_field("busy_res",    want.busy_res,    rsp_tdata[12]);
            check_field("done_res",    want.done_res,    rsp_tlast);
            check_field("outcome",     want.outcome,     rsp_tdata[14:13]);
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         s.start_req      = req_tdata[0];
         s.turn_right     = req_tdata[1];
         s.odometry_level = req_tdata[2];
         s.uv_left        = req_tdata[12:3];
         s.uv_right       = req_tdata[22:13];
         command_q.push_back(step_locator(model_st, model_cfg, s));
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // Write one register and mirror it in the predictor on acceptance.
   task automatic write_csr(input logic [uvps_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [uvps_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         uvps_pkg::REG_SWEEP_TICKS: begin
            model_cfg.sweep_ticks = val;
         end
         uvps_pkg::REG_UV_THRESHOLD: begin
            model_cfg.uv_threshold = val[uvps_pkg::UV_THRESHOLD_W-1:0];
         end
         uvps_pkg::REG_MOTOR_SPEED: begin
            model_cfg.motor_speed = val[uvps_pkg::MOTOR_SPEED_W-1:0];
         end
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all(input int ticks, input int thr, input int speed);
      write_csr(uvps_pkg::REG_SWEEP_TICKS, ticks[uvps_pkg::CSR_DATA_W-1:0]);
      write_csr(uvps_pkg::REG_UV_THRESHOLD, thr[uvps_pkg::CSR_DATA_W-1:0]);
      write_csr(uvps_pkg::REG_MOTOR_SPEED, speed[uvps_pkg::CSR_DATA_W-1:0]);
   endtask

   // Hold until every item went through, every command came back and the
   // sequencer is back in idle.
   task automatic wait_drained();
      while (sensor_q.size() != 0 || req_tvalid || command_q.size() != 0 ||
             model_st.ph != uvps_pkg::PH_IDLE)
         @(negedge clock);
   endtask

   // Queue one item; adv moves the encoder level off its last counted value.
   task automatic push_step(input int go, input int dir, input int adv,
                            input int ul, input int ur);
      uvps_pkg::req_type s;
      s.start_req      = (go != 0);
      s.turn_right     = (dir != 0);
      s.odometry_level = (adv != 0) ? ~plan_st.last_lvl : plan_st.last_lvl;
      s.uv_left        = ul[uvps_pkg::UV_W-1:0];
      s.uv_right       = ur[uvps_pkg::UV_W-1:0];
      if (plan_st.ph != uvps_pkg::PH_IDLE || go != 0) planned++;
      void'(step_locator(plan_st, model_cfg, s));
      sensor_q.push_back(s);
   endtask

   // Sweep samples stay at or under uv_cap, with rare spikes to full scale when
   // uv_cap is full scale; the rest of the sequence sees the whole range.
   function automatic int pick_uv();
      if (plan_st.ph != uvps_pkg::PH_SWEEP) return $urandom_range(0, 1023);
      if (uv_cap == 1023 && $urandom_range(0, 19) == 0) return 1023;
      return $urandom_range(0, uv_cap);
   endfunction

   // Idle: mostly a start with fresh sequence settings, else noise.
   // Busy: encoder edges at the sequence rate, stray starts now and then.
   task automatic push_random();
      logic go;
      logic adv;
      if (plan_st.ph == uvps_pkg::PH_IDLE) begin
         go  = ($urandom_range(0, 99) < 75);
         adv = ($urandom_range(0, 1) == 1);
         if (go) begin
            toggle_pct = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(50, 100);
            uv_cap = ($urandom_range(0, 3) == 0 && model_cfg.uv_threshold != 0)
                     ? model_cfg.uv_threshold - 1 : 1023;
         end
      end else begin
         go  = ($urandom_range(0, 9) == 0);
         adv = ($urandom_range(1, 100) <= toggle_pct);
      end
      push_step(go, ($urandom_range(0, 1) == 1), adv, pick_uv(), pick_uv());
   endtask

   initial begin
      model_st          = '0;
      model_st.ph       = uvps_pkg::PH_IDLE;
      model_st.last_out = uvps_pkg::OUT_NONE;
      plan_st           = model_st;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: short sweeps hitting each outcome
      write_all(2, 512, 255);
      push_step(0, 0, 0, 1023, 1023);   // idle, no start: ignored
      // right sweep, peak on the first sample: straight ahead
      push_step(1, 1, 0, 1023, 0);
      push_step(0, 0, 1, 1023, 0);
      push_step(1, 0, 1, 0, 0);         // start while busy is dropped
      push_step(0, 0, 1, 0, 0);
      push_step(0, 0, 1, 900, 3);       // leading sensor still low
      push_step(0, 0, 0, 3, 3);         // equal readings count as centered
      // left sweep, peak on the last sample: corner
      push_step(1, 0, 0, 0, 0);
      push_step(0, 1, 1, 0, 0);
      push_step(0, 0, 1, 700, 1023);
      push_step(0, 0, 1, 0, 1023);
      push_step(0, 0, 0, 1023, 1023);
      // left sweep just under threshold: extra sweep, no target
      push_step(1, 0, 1, 0, 0);
      push_step(0, 0, 1, 511, 511);
      push_step(0, 0, 1, 0, 511);
      push_step(0, 0, 0, 0, 0);
      push_step(0, 0, 1, 0, 0);
      push_step(0, 0, 1, 0, 0);
      wait_drained();

      // Zero-length sweep with zero threshold: peak never raised, side
      write_all(0, 0, 0);
      push_step(1, 1, 0, 0, 0);
      push_step(0, 0, 0, 0, 0);
      push_step(0, 1, 0, 0, 0);
      wait_drained();

      // Long sweep with the highest threshold, one edge per item
      write_all(250, 1023, 1);
      push_step(1, 1, 0, 0, 0);
      toggle_pct = 100;
      uv_cap     = 1023;
      do push_random(); while (plan_st.ph != uvps_pkg::PH_IDLE);
      wait_drained();

      // Random phases, each under its own settings; phase 0 runs without gaps
      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p)
            0:       write_all(1, $urandom_range(0, 1023), $urandom_range(0, 255));
            1:       write_all($urandom_range(1, 24), 1023, 255);
            2:       write_all($urandom_range(1, 24), 0, 0);
            3:       write_all($urandom_range(30, 80), $urandom_range(0, 1023),
                               $urandom_range(0, 255));
            default: write_all($urandom_range(1, 24), $urandom_range(0, 1023),
                               $urandom_range(0, 255));
         endcase
         req_idle_pct = (p == 0) ? 0 : $urandom_range(10, 40);
         rsp_idle_pct = (p == 0) ? 0 : $urandom_range(10, 40);
         planned = 0;
         while (planned < PHASE_ITEMS || plan_st.ph != uvps_pkg::PH_IDLE) push_random();
         wait_drained();
      end

      // Let any stray command show up before the verdict
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/uvps_pkg.sv
rtl/core/uvps_engine.sv
rtl/core/uv_peak_sweep_locator_top.sv
test/uv_peak_sweep_locator_top_test.sv
